@@ sv/trr_pkg.sv @@
// Package for the TFTP read receiver: sizes, command, event, status and
// register codes, and the result record held in the result queue.
// No dependencies.
package trr_pkg;

    // Data block size of the transfer and the TFTP header length
    localparam int BLOCK_SIZE = 512;
    localparam int HDR_LEN    = 4;
    localparam int PKT_LIMIT  = HDR_LEN + BLOCK_SIZE;
    localparam int IDX_W      = $clog2(PKT_LIMIT + 1);

    localparam logic [15:0] PORT_REQ = 16'd69;
    localparam logic [15:0] OP_DATA  = 16'd3;

    // Input request kinds
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Result events
    localparam logic [1:0] EV_WRITE  = 2'd0;
    localparam logic [1:0] EV_REQ    = 2'd1;
    localparam logic [1:0] EV_ACK    = 2'd2;
    localparam logic [1:0] EV_FINISH = 2'd3;

    // Transfer status
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RUN     = 3'd1;
    localparam logic [2:0] ST_OK      = 3'd2;
    localparam logic [2:0] ST_PKTFAIL = 3'd3;
    localparam logic [2:0] ST_TOFAIL  = 3'd4;

    // Packet classification after the block number
    localparam logic [1:0] CLS_NONE   = 2'd0;
    localparam logic [1:0] CLS_EXPECT = 2'd1;
    localparam logic [1:0] CLS_REPEAT = 2'd2;
    localparam logic [1:0] CLS_DROP   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_SERVER   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd2;
    localparam logic [1:0] CFG_RETRY    = 2'd3;

    localparam logic [31:0] CAPACITY_RST = 32'd65536;
    localparam logic [31:0] TIMEOUT_RST  = 32'd3000;
    localparam logic [3:0]  RETRY_RST    = 4'd5;

    // Result queue sizing: one request makes at most RES_MAX results
    localparam int RES_MAX   = 3;
    localparam int RES_DEPTH = 4;
    localparam int PTR_W     = $clog2(RES_DEPTH);
    localparam int CNT_W     = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  event_res;
        logic [31:0] write_addr;
        logic [7:0]  write_byte;
        logic [15:0] ack_block;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic [2:0]  status;
        logic [31:0] length;
        logic        last;
    } res_t;

endpackage

@@ sv/trr_if.sv @@
// Channel interfaces of the TFTP read receiver: input request channel and
// result channel, each with valid/ready. No dependencies.
interface trr_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  rx_byte;
    logic        rx_last;
    logic [31:0] src_addr;
    logic [15:0] src_port;

    modport source (output valid, cmd, rx_byte, rx_last, src_addr, src_port, input ready);
    modport sink (input valid, cmd, rx_byte, rx_last, src_addr, src_port, output ready);
endinterface

interface trr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [31:0] write_addr;
    logic [7:0]  write_byte;
    logic [15:0] ack_block;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [2:0]  status;
    logic [31:0] length;
    logic        last;

    modport source (output valid, event_res, write_addr, write_byte, ack_block, peer_addr,
                    peer_port, status, length, last, input ready);
    modport sink (input valid, event_res, write_addr, write_byte, ack_block, peer_addr,
                  peer_port, status, length, last, output ready);
endinterface

@@ sv/tftp_read_receiver_core.sv @@
// Top level of the TFTP read receiver (octet mode, receive side).
// Depends on trr_pkg and the channel interfaces in trr_if.sv.
//
// Usage:
//   item   - request channel. cmd selects start, received UDP byte or time
//            tick; byte requests carry the byte, its end-of-packet mark and
//            the packet's source address and port.
//   result - result channel: write, read request, ACK and finished events,
//            with status and accepted length after the request; last marks
//            the final result of a request.
//   cfg_*  - register writes (capacity, server_ip, timeout_ticks,
//            retry_limit), done while the block is idle.
// Each request is decoded in the cycle it is accepted; its results (zero to
// three) enter a four-entry result queue and show on the result channel
// from the next cycle, one per cycle. Requests are taken every cycle while
// the queue has room for three results, so with the result receiver ready a
// stream of bytes that each make at most one result runs at one per cycle;
// the queue drain rate of one result per cycle sets the pace otherwise.
// Reset clears the transfer to idle and the registers to their defaults.
// When the result receiver stalls, the queue holds its results and item
// ready drops once fewer than three entries are free.
module tftp_read_receiver_core
    import trr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    trr_item_if.sink    item,
    trr_res_if.source   result
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    // Configuration registers
    logic [31:0] capacity_reg;
    logic [31:0] server_ip_reg;
    logic [31:0] timeout_reg;
    logic [3:0]  retry_limit_reg;

    // Transfer state
    logic [1:0]       phase_reg, phase_next;
    logic [15:0]      expected_reg, expected_next;
    logic [31:0]      bytes_got_reg, bytes_got_next;
    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [23:0]      header_reg, header_next;
    logic [1:0]       class_reg, class_next;
    logic [3:0]       retry_reg, retry_next;
    logic [31:0]      tick_reg, tick_next;
    logic [31:0]      peer_ip_reg, peer_ip_next;
    logic [15:0]      peer_port_reg, peer_port_next;
    logic [2:0]       status_reg, status_next;

    // Result queue
    res_t             queue_reg [RES_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    res_t               slot     [RES_MAX];
    res_t               slot_fin [RES_MAX];
    logic [RES_MAX-1:0] slot_vld;
    logic [PTR_W-1:0]   slot_pos [RES_MAX];
    logic [CNT_W-1:0]   push_cnt;

    logic item_fire;
    logic res_fire;

    // Byte decode helpers
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] cnt;
    logic [IDX_W-1:0] dlen;
    logic             idx_in_pkt;
    logic [15:0]      op_hdr;
    logic [15:0]      blk;
    logic [16:0]      blk_inc;
    logic [1:0]       cls_at3;
    logic [1:0]       cls_eff;
    logic [32:0]      wr_addr_wide;
    logic [32:0]      got_sum;
    logic [31:0]      tick_inc;

    assign item_fire  = item.valid && item.ready;
    assign res_fire   = result.valid && result.ready;
    assign item.ready = (count_reg <= CNT_W'(RES_DEPTH - RES_MAX));

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= CAPACITY_RST;
            server_ip_reg   <= '0;
            timeout_reg     <= TIMEOUT_RST;
            retry_limit_reg <= RETRY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAPACITY: capacity_reg    <= cfg_data;
                CFG_SERVER:   server_ip_reg   <= cfg_data;
                CFG_TIMEOUT:  timeout_reg     <= cfg_data;
                CFG_RETRY:    retry_limit_reg <= cfg_data[3:0];
            endcase
        end
    end

    // Decode the current byte against the packet state
    assign idx        = byte_index_reg;
    assign idx_in_pkt = (idx < IDX_W'(PKT_LIMIT));
    assign cnt        = idx_in_pkt ? idx + IDX_W'(1) : idx;
    assign dlen       = cnt - IDX_W'(HDR_LEN);
    assign op_hdr     = header_reg[23:8];
    assign blk        = {header_reg[7:0], item.rx_byte};
    assign blk_inc    = {1'b0, blk} + 17'd1;
    assign cls_at3    = (op_hdr != OP_DATA)                                    ? CLS_DROP   :
                        (blk == expected_reg)                                  ? CLS_EXPECT :
                        ((blk_inc == {1'b0, expected_reg}) && (expected_reg > 16'd1))
                                                                               ? CLS_REPEAT :
                                                                                 CLS_DROP;
    assign cls_eff      = (idx == IDX_W'(3)) ? cls_at3 : class_reg;
    assign wr_addr_wide = {1'b0, bytes_got_reg} + 33'(idx - IDX_W'(HDR_LEN));
    assign got_sum      = {1'b0, bytes_got_reg} + 33'(dlen);
    assign tick_inc     = tick_reg + 32'd1;

    // Next state and the results of the accepted request
    always_comb
    begin
        phase_next      = phase_reg;
        expected_next   = expected_reg;
        bytes_got_next  = bytes_got_reg;
        byte_index_next = byte_index_reg;
        header_next     = header_reg;
        class_next      = class_reg;
        retry_next      = retry_reg;
        tick_next       = tick_reg;
        peer_ip_next    = peer_ip_reg;
        peer_port_next  = peer_port_reg;
        status_next     = status_reg;
        slot_vld        = '0;
        for (int k = 0; k < RES_MAX; k++)
        begin
            slot[k] = '0;
        end

        if (item_fire)
        begin
            unique case (item.cmd)
                CMD_START:
                begin
                    phase_next        = PH_RUN;
                    status_next       = ST_RUN;
                    bytes_got_next    = '0;
                    expected_next     = 16'd1;
                    retry_next        = '0;
                    tick_next         = '0;
                    byte_index_next   = '0;
                    header_next       = '0;
                    class_next        = CLS_NONE;
                    peer_ip_next      = server_ip_reg;
                    peer_port_next    = PORT_REQ;
                    slot_vld[1]       = 1'b1;
                    slot[1].event_res = EV_REQ;
                    slot[1].peer_addr = server_ip_reg;
                    slot[1].peer_port = PORT_REQ;
                end
                CMD_BYTE:
                begin
                    if (phase_reg == PH_RUN)
                    begin
                        peer_ip_next   = item.src_addr;
                        peer_port_next = item.src_port;
                        // Collect header, classify at the block number, write payload
                        if (idx < IDX_W'(3))
                        begin
                            header_next = {header_reg[15:0], item.rx_byte};
                        end
                        else if (idx == IDX_W'(3))
                        begin
                            class_next = cls_at3;
                        end
                        else if (idx_in_pkt && (class_reg == CLS_EXPECT)
                                 && (wr_addr_wide < {1'b0, capacity_reg}))
                        begin
                            slot_vld[0]        = 1'b1;
                            slot[0].event_res  = EV_WRITE;
                            slot[0].write_addr = wr_addr_wide[31:0];
                            slot[0].write_byte = item.rx_byte;
                        end
                        byte_index_next = cnt;

                        // Close the packet on its final byte
                        if (item.rx_last)
                        begin
                            byte_index_next = '0;
                            header_next     = '0;
                            class_next      = CLS_NONE;
                            if ((cnt < IDX_W'(HDR_LEN)) || (op_hdr != OP_DATA)
                                || ((cls_eff == CLS_EXPECT)
                                    && (got_sum > {1'b0, capacity_reg})))
                            begin
                                phase_next        = PH_DONE;
                                status_next       = ST_PKTFAIL;
                                slot_vld[1]       = 1'b1;
                                slot[1].event_res = EV_FINISH;
                            end
                            else if (cls_eff == CLS_REPEAT)
                            begin
                                tick_next         = '0;
                                slot_vld[1]       = 1'b1;
                                slot[1].event_res = EV_ACK;
                                slot[1].ack_block = expected_reg - 16'd1;
                                slot[1].peer_addr = item.src_addr;
                                slot[1].peer_port = item.src_port;
                            end
                            else if (cls_eff != CLS_EXPECT)
                            begin
                                tick_next = '0;
                            end
                            else
                            begin
                                bytes_got_next    = got_sum[31:0];
                                expected_next     = expected_reg + 16'd1;
                                retry_next        = '0;
                                tick_next         = '0;
                                slot_vld[1]       = 1'b1;
                                slot[1].event_res = EV_ACK;
                                slot[1].ack_block = expected_reg;
                                slot[1].peer_addr = item.src_addr;
                                slot[1].peer_port = item.src_port;
                                if (dlen < IDX_W'(BLOCK_SIZE))
                                begin
                                    phase_next        = PH_DONE;
                                    status_next       = ST_OK;
                                    slot_vld[2]       = 1'b1;
                                    slot[2].event_res = EV_FINISH;
                                end
                            end
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (phase_reg == PH_RUN)
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= timeout_reg)
                        begin
                            tick_next   = '0;
                            slot_vld[1] = 1'b1;
                            if (retry_reg >= retry_limit_reg)
                            begin
                                phase_next        = PH_DONE;
                                status_next       = ST_TOFAIL;
                                byte_index_next   = '0;
                                header_next       = '0;
                                class_next        = CLS_NONE;
                                slot[1].event_res = EV_FINISH;
                            end
                            else
                            begin
                                retry_next        = retry_reg + 4'd1;
                                slot[1].peer_addr = peer_ip_reg;
                                if (expected_reg == 16'd1)
                                begin
                                    slot[1].event_res = EV_REQ;
                                    slot[1].peer_port = PORT_REQ;
                                end
                                else
                                begin
                                    slot[1].event_res = EV_ACK;
                                    slot[1].ack_block = expected_reg - 16'd1;
                                    slot[1].peer_port = peer_port_reg;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Stamp status, length and last mark; pack valid slots in order
    always_comb
    begin
        push_cnt = '0;
        for (int k = 0; k < RES_MAX; k++)
        begin
            slot_pos[k]        = wr_ptr_reg + PTR_W'(push_cnt);
            push_cnt           = push_cnt + CNT_W'(slot_vld[k]);
            slot_fin[k]        = slot[k];
            slot_fin[k].status = status_next;
            slot_fin[k].length = bytes_got_next;
            slot_fin[k].last   = slot_vld[k];
            for (int j = k + 1; j < RES_MAX; j++)
            begin
                if (slot_vld[j])
                begin
                    slot_fin[k].last = 1'b0;
                end
            end
        end
    end

    // Transfer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            expected_reg   <= 16'd1;
            bytes_got_reg  <= '0;
            byte_index_reg <= '0;
            header_reg     <= '0;
            class_reg      <= CLS_NONE;
            retry_reg      <= '0;
            tick_reg       <= '0;
            peer_ip_reg    <= '0;
            peer_port_reg  <= PORT_REQ;
            status_reg     <= ST_IDLE;
        end
        else
        begin
            phase_reg      <= phase_next;
            expected_reg   <= expected_next;
            bytes_got_reg  <= bytes_got_next;
            byte_index_reg <= byte_index_next;
            header_reg     <= header_next;
            class_reg      <= class_next;
            retry_reg      <= retry_next;
            tick_reg       <= tick_next;
            peer_ip_reg    <= peer_ip_next;
            peer_port_reg  <= peer_port_next;
            status_reg     <= status_next;
        end
    end

    // Result queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(res_fire);
            count_reg  <= count_reg + push_cnt - CNT_W'(res_fire);
        end
    end

    // Result queue entries
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RES_MAX; k++)
        begin
            if (slot_vld[k])
            begin
                queue_reg[slot_pos[k]] <= slot_fin[k];
            end
        end
    end

    // Drive the result channel from the queue head
    assign result.valid      = (count_reg != '0);
    assign result.event_res  = queue_reg[rd_ptr_reg].event_res;
    assign result.write_addr = queue_reg[rd_ptr_reg].write_addr;
    assign result.write_byte = queue_reg[rd_ptr_reg].write_byte;
    assign result.ack_block  = queue_reg[rd_ptr_reg].ack_block;
    assign result.peer_addr  = queue_reg[rd_ptr_reg].peer_addr;
    assign result.peer_port  = queue_reg[rd_ptr_reg].peer_port;
    assign result.status     = queue_reg[rd_ptr_reg].status;
    assign result.length     = queue_reg[rd_ptr_reg].length;
    assign result.last       = queue_reg[rd_ptr_reg].last;

endmodule

@@ sv/trr_checker.sv @@
// Port-level checks for the TFTP read receiver, bound to the top level.
// Depends on trr_pkg and tftp_read_receiver_core.
module trr_checker
    import trr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  in_cmd,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_event,
    input logic [31:0] out_waddr,
    input logic [15:0] out_port,
    input logic [2:0]  out_status,
    input logic        out_last
);

    // Hold a stalled result unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_event) && $stable(out_waddr)
                                    && $stable(out_last))
        else $error("stalled result changed");

    // A start request yields a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_cmd == CMD_START) |=> out_valid)
        else $error("start request produced no result");

    // A finished event carries a final status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_event == EV_FINISH) |->
            (out_status == ST_OK) || (out_status == ST_PKTFAIL) || (out_status == ST_TOFAIL))
        else $error("finished event without final status");

    // A read request goes to the request port of a running transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_event == EV_REQ) |-> (out_port == PORT_REQ) && (out_status == ST_RUN))
        else $error("bad read request event");

endmodule

bind tftp_read_receiver_core trr_checker u_trr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .in_cmd     (item.cmd),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_event  (result.event_res),
    .out_waddr  (result.write_addr),
    .out_port   (result.peer_port),
    .out_status (result.status),
    .out_last   (result.last)
);

@@ sim/tftp_read_receiver_core_tb.sv @@
// Testbench for tftp_read_receiver_core: directed and random request streams
// checked against a cycle-free transfer predictor, with random idling on both
// channels. Depends on trr_pkg, trr_if.sv and the block itself.
`timescale 1ns / 1ps

module tftp_read_receiver_core_tb;
    import trr_pkg::*;

    typedef enum logic [1:0] {XFER_IDLE, XFER_RUN, XFER_DONE} xfer_phase_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    trr_item_if item_ch ();
    trr_res_if  res_ch ();

    tftp_read_receiver_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (res_ch)
    );

    // Register copies
    logic [31:0] cap_reg;
    logic [31:0] server_reg;
    logic [31:0] timeout_reg;
    logic [3:0]  retry_lim;

    // Transfer state
    xfer_phase_t          xfer_phase;
    logic [15:0]          want_block;
    logic [31:0]          bytes_stored;
    logic [IDX_W-1:0]     pkt_index;
    logic [23:0]          hdr_shift;
    logic [1:0]           pkt_class;
    logic [3:0]           retries_used;
    logic [31:0]          idle_ticks;
    logic [31:0]          peer_ip_q;
    logic [15:0]          peer_port_q;
    logic [2:0]           xfer_status;

    res_t item_events[$];
    res_t awaited_results[$];

    int  mismatches;
    int  accepted_items;
    int  acted_items;
    int  results_checked;
    bit  no_gaps;
    bit  no_stalls;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Limit on the whole run
    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Transfer predictor
    // ------------------------------------------------------------------
    task automatic add_event(input logic [1:0] ev, input logic [31:0] waddr,
                             input logic [7:0] wbyte, input logic [15:0] ack,
                             input logic [31:0] paddr, input logic [15:0] pport);
        res_t r;
        r = '0;
        r.event_res  = ev;
        r.write_addr = waddr;
        r.write_byte = wbyte;
        r.ack_block  = ack;
        r.peer_addr  = paddr;
        r.peer_port  = pport;
        item_events.push_back(r);
    endtask

    task automatic clear_packet();
        pkt_index = '0;
        hdr_shift = '0;
        pkt_class = CLS_NONE;
    endtask

    task automatic fail_transfer(input logic [2:0] code);
        xfer_phase  = XFER_DONE;
        xfer_status = code;
        clear_packet();
        add_event(EV_FINISH, '0, '0, '0, '0, '0);
    endtask

    task automatic close_packet();
        logic [IDX_W-1:0] cnt;
        logic [15:0]      op;
        logic [1:0]       cls;
        logic [31:0]      dlen;
        logic [32:0]      total;
        cnt = pkt_index;
        op  = hdr_shift[23:8];
        cls = pkt_class;
        clear_packet();
        if (cnt < HDR_LEN || op != OP_DATA)
        begin
            fail_transfer(ST_PKTFAIL);
        end
        else if (cls == CLS_REPEAT)
        begin
            add_event(EV_ACK, '0, '0, want_block - 16'd1, peer_ip_q, peer_port_q);
            idle_ticks = '0;
        end
        else if (cls != CLS_EXPECT)
        begin
            idle_ticks = '0;
        end
        else
        begin
            dlen  = 32'(cnt) - HDR_LEN;
            total = {1'b0, bytes_stored} + {1'b0, dlen};
            if (total > {1'b0, cap_reg})
            begin
                fail_transfer(ST_PKTFAIL);
            end
            else
            begin
                bytes_stored = total[31:0];
                add_event(EV_ACK, '0, '0, want_block, peer_ip_q, peer_port_q);
                want_block   = want_block + 16'd1;
                retries_used = '0;
                idle_ticks   = '0;
                // A short block ends the transfer
                if (dlen < BLOCK_SIZE)
                begin
                    xfer_phase  = XFER_DONE;
                    xfer_status = ST_OK;
                    add_event(EV_FINISH, '0, '0, '0, '0, '0);
                end
            end
        end
    endtask

    task automatic take_byte(input logic [7:0] b, input logic lastb,
                             input logic [31:0] addr, input logic [15:0] port);
        logic [IDX_W-1:0] idx;
        logic [15:0]      op;
        logic [15:0]      blk;
        logic [32:0]      waddr;
        idx         = pkt_index;
        peer_ip_q   = addr;
        peer_port_q = port;
        if (idx < 3)
        begin
            hdr_shift = {hdr_shift[15:0], b};
        end
        else if (idx == 3)
        begin
            // Classify on the block number
            op  = hdr_shift[23:8];
            blk = {hdr_shift[7:0], b};
            if (op != OP_DATA)
                pkt_class = CLS_DROP;
            else if (blk == want_block)
                pkt_class = CLS_EXPECT;
            else if ({1'b0, blk} + 17'd1 == {1'b0, want_block} && want_block > 16'd1)
                pkt_class = CLS_REPEAT;
            else
                pkt_class = CLS_DROP;
        end
        else if (idx < PKT_LIMIT && pkt_class == CLS_EXPECT)
        begin
            waddr = {1'b0, bytes_stored} + 33'(idx - HDR_LEN);
            if (waddr < {1'b0, cap_reg})
                add_event(EV_WRITE, waddr[31:0], b, '0, '0, '0);
        end
        if (idx < PKT_LIMIT)
            pkt_index = idx + 1'b1;
        if (lastb)
            close_packet();
    endtask

    task automatic take_tick();
        idle_ticks = idle_ticks + 32'd1;
        if (idle_ticks >= timeout_reg)
        begin
            idle_ticks = '0;
            if (retries_used >= retry_lim)
            begin
                fail_transfer(ST_TOFAIL);
            end
            else
            begin
                retries_used = retries_used + 4'd1;
                if (want_block == 16'd1)
                    add_event(EV_REQ, '0, '0, '0, peer_ip_q, PORT_REQ);
                else
                    add_event(EV_ACK, '0, '0, want_block - 16'd1, peer_ip_q, peer_port_q);
            end
        end
    endtask

    task automatic predict_item(input logic [1:0] cmd, input logic [7:0] b,
                                input logic lastb, input logic [31:0] addr,
                                input logic [15:0] port);
        res_t r;
        item_events.delete();
        if (cmd == CMD_START)
        begin
            xfer_phase   = XFER_RUN;
            xfer_status  = ST_RUN;
            bytes_stored = '0;
            want_block   = 16'd1;
            retries_used = '0;
            idle_ticks   = '0;
            clear_packet();
            peer_ip_q    = server_reg;
            peer_port_q  = PORT_REQ;
            add_event(EV_REQ, '0, '0, '0, peer_ip_q, PORT_REQ);
        end
        else if (cmd == CMD_BYTE && xfer_phase == XFER_RUN)
        begin
            take_byte(b, lastb, addr, port);
        end
        else if (cmd == CMD_TICK && xfer_phase == XFER_RUN)
        begin
            take_tick();
        end
        // Status and length reflect the state after the whole request
        for (int k = 0; k < item_events.size(); k++)
        begin
            r        = item_events[k];
            r.status = xfer_status;
            r.length = bytes_stored;
            r.last   = (k == item_events.size() - 1);
            awaited_results.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
                             input logic lastb, input logic [31:0] addr,
                             input logic [15:0] port);
        int gap;
        if ($urandom_range(0, 63) == 0)
            no_gaps = !no_gaps;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.cmd      <= cmd;
        item_ch.rx_byte  <= b;
        item_ch.rx_last  <= lastb;
        item_ch.src_addr <= addr;
        item_ch.src_port <= port;
        do
            @(posedge clk);
        while (!item_ch.ready);
        accepted_items++;
        if (cmd == CMD_START || ((cmd == CMD_BYTE || cmd == CMD_TICK) && xfer_phase == XFER_RUN))
            acted_items++;
        predict_item(cmd, b, lastb, addr, port);
    endtask

    // Send one UDP payload: header word first, random bytes after it
    task automatic send_packet(input logic [15:0] opcode, input logic [15:0] blk,
                               input int nbytes, input bit closed,
                               input logic [31:0] addr, input logic [15:0] port);
        logic [31:0] hdr;
        logic [7:0]  b;
        hdr = {opcode, blk};
        for (int i = 0; i < nbytes; i++)
        begin
            if (i < HDR_LEN)
                b = 8'(hdr >> (8 * (3 - i)));
            else
                b = 8'($urandom_range(0, 255));
            send_item(CMD_BYTE, b, closed && (i == nbytes - 1), addr, port);
        end
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_item(CMD_TICK, 8'($urandom), 1'($urandom), $urandom, 16'($urandom));
    endtask

    // Hold requests off until every awaited result is back, then let the
    // block settle
    task automatic drain();
        int waited;
        waited = 0;
        item_ch.valid <= 1'b0;
        while (awaited_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] cap, input logic [31:0] ip,
                             input logic [31:0] ticks, input logic [3:0] retries);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CAPACITY;
        cfg_data  <= cap;
        @(posedge clk);
        cfg_index <= CFG_SERVER;
        cfg_data  <= ip;
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= ticks;
        @(posedge clk);
        // Upper bits of the retry write are not stored
        cfg_index <= CFG_RETRY;
        cfg_data  <= {28'($urandom), retries};
        @(posedge clk);
        cfg_we      <= 1'b0;
        cap_reg     = cap;
        server_reg  = ip;
        timeout_reg = ticks;
        retry_lim   = retries;
    endtask

    // ------------------------------------------------------------------
    // Result checker with random stalls
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        int   stall;
        res_t want;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                no_stalls = !no_stalls;
            stall = no_stalls ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            results_checked++;
            if (awaited_results.size() == 0)
            begin
                $error("result with no request behind it: event_res %0d", res_ch.event_res);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("event_res", want.event_res, res_ch.event_res);
                check_field("write_addr", want.write_addr, res_ch.write_addr);
                check_field("write_byte", want.write_byte, res_ch.write_byte);
                check_field("ack_block", want.ack_block, res_ch.ack_block);
                check_field("peer_addr", want.peer_addr, res_ch.peer_addr);
                check_field("peer_port", want.peer_port, res_ch.peer_port);
                check_field("status", want.status, res_ch.status);
                check_field("length", want.length, res_ch.length);
                check_field("last", want.last, res_ch.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Ignored requests, request resend to the learned peer, timeout failure
    task automatic test_timeouts();
        logic [31:0] addr;
        logic [15:0] port;
        addr = $urandom;
        port = 16'($urandom);
        drain();
        send_item(CMD_BYTE, 8'hFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_TICK, 8'h00, 1'b0, 32'h0, 16'h0);
        send_item(2'b11, 8'hA5, 1'b1, $urandom, 16'($urandom));
        drain();
        configure(CAPACITY_RST, 32'hFFFF_FFFF, 32'd1, 4'd1);
        send_item(CMD_START, 8'h00, 1'b0, 32'h0, 16'h0);
        // Tick lands in mid-packet
        send_packet(OP_DATA, 16'd1, 1, 1'b0, addr, port);
        send_ticks(2);
        send_ticks(1);
    endtask

    // Overflow, short packet, error opcode, restart mid-packet, empty block
    task automatic test_packet_faults();
        drain();
        configure(32'd1, 32'h0, 32'hFFFF_FFFF, 4'd0);
        send_item(CMD_START, 8'h00, 1'b0, 32'h0, 16'h0);
        send_packet(OP_DATA, 16'd1, 6, 1'b1, $urandom, 16'($urandom));
        send_item(CMD_START, 8'h00, 1'b0, 32'h0, 16'h0);
        send_packet(OP_DATA, 16'd1, 3, 1'b1, $urandom, 16'($urandom));
        send_item(CMD_START, 8'h00, 1'b0, 32'h0, 16'h0);
        send_packet(16'd5, 16'd1, 4, 1'b1, $urandom, 16'($urandom));
        send_item(CMD_START, 8'h00, 1'b0, 32'h0, 16'h0);
        send_packet(OP_DATA, 16'd1, 2, 1'b0, $urandom, 16'($urandom));
        send_ticks(1);
        send_item(CMD_START, 8'h00, 1'b0, 32'h0, 16'h0);
        send_packet(OP_DATA, 16'd1, 4, 1'b1, $urandom, 16'($urandom));
    endtask

    // Long full block, repeat, dropped block, ACK resend, exact fit
    task automatic test_multi_block();
        drain();
        configure(32'd522, $urandom, 32'd2, 4'd15);
        send_item(CMD_START, 8'h00, 1'b0, 32'h0, 16'h0);
        send_packet(OP_DATA, 16'd1, PKT_LIMIT + 14, 1'b1, $urandom, 16'($urandom));
        send_packet(OP_DATA, 16'd1, 6, 1'b1, $urandom, 16'($urandom));
        send_packet(OP_DATA, 16'd9, 5, 1'b1, $urandom, 16'($urandom));
        send_ticks(2);
        send_packet(OP_DATA, 16'd2, HDR_LEN + 10, 1'b1, $urandom, 16'($urandom));
    endtask

    // Mostly well-formed packets with random content, plus noise
    task automatic random_phase(input logic [31:0] cap, input logic [31:0] ip,
                                input logic [31:0] ticks, input logic [3:0] retries,
                                input int budget);
        int          goal;
        int          r;
        logic [15:0] blk;
        logic [15:0] opcode;
        drain();
        configure(cap, ip, ticks, retries);
        goal = acted_items + budget;
        while (acted_items < goal)
        begin
            r = $urandom_range(0, 99);
            if (xfer_phase != XFER_RUN && r < 80)
            begin
                send_item(CMD_START, 8'($urandom), 1'($urandom), $urandom, 16'($urandom));
            end
            else if (r < 5)
            begin
                send_item(CMD_START, 8'($urandom), 1'($urandom), $urandom, 16'($urandom));
            end
            else if (r < 55)
            begin
                r = $urandom_range(0, 99);
                blk = (r < 75) ? want_block : (r < 85) ? want_block - 16'd1 : 16'($urandom);
                opcode = ($urandom_range(0, 9) == 0) ? 16'($urandom) : OP_DATA;
                send_packet(opcode, blk, HDR_LEN + $urandom_range(0, 12), 1'b1,
                            $urandom, 16'($urandom));
            end
            else if (r < 65)
            begin
                send_packet(16'($urandom), 16'($urandom), $urandom_range(1, 6), 1'b1,
                            $urandom, 16'($urandom));
            end
            else if (r < 85)
            begin
                send_ticks($urandom_range(1, 4));
            end
            else if (r < 92)
            begin
                send_item(2'b11, 8'($urandom), 1'($urandom), $urandom, 16'($urandom));
            end
            else
            begin
                send_item(CMD_BYTE, 8'($urandom), 1'($urandom), $urandom, 16'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        random_phase(32'($urandom_range(1, 40)), $urandom, 32'd1, 4'd0, 30);
        random_phase(32'hFFFF_FFFF, 32'h0, 32'($urandom_range(2, 4)), 4'd15, 30);
        random_phase(32'd1, $urandom, 32'd3, 4'($urandom_range(1, 3)), 30);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_CAPACITY;
        cfg_data         = '0;
        item_ch.valid    = 1'b0;
        item_ch.cmd      = CMD_TICK;
        item_ch.rx_byte  = '0;
        item_ch.rx_last  = 1'b0;
        item_ch.src_addr = '0;
        item_ch.src_port = '0;
        res_ch.ready     = 1'b0;

        cap_reg      = CAPACITY_RST;
        server_reg   = '0;
        timeout_reg  = TIMEOUT_RST;
        retry_lim    = RETRY_RST;
        xfer_phase   = XFER_IDLE;
        want_block   = 16'd1;
        bytes_stored = '0;
        clear_packet();
        retries_used = '0;
        idle_ticks   = '0;
        peer_ip_q    = '0;
        peer_port_q  = PORT_REQ;
        xfer_status  = ST_IDLE;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_timeouts();
        test_packet_faults();
        test_multi_block();
        test_random_traffic();
        drain();

        if (awaited_results.size() != 0)
        begin
            $error("%0d awaited results never arrived", awaited_results.size());
            mismatches++;
        end
        $display("Ran %0d requests (%0d acted on) and checked %0d results:",
                 accepted_items, acted_items, results_checked);
        $display("timeouts, packet faults, multi-block transfer and three random settings.");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/trr_pkg.sv
sv/trr_if.sv
sv/tftp_read_receiver_core.sv
sv/trr_checker.sv
sim/tftp_read_receiver_core_tb.sv
